FILE: design/fscl_pkg.sv
package fscl_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LIMIT_W  = 8;
  localparam int unsigned TRAIL_W  = 6;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POLL   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BYTE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FINISH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DONE   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAIL_CNT  = 1'd1;

  localparam logic [LIMIT_W-1:0] POLL_LIMIT_RST = 8'd100;
  localparam logic [TRAIL_W-1:0] TRAIL_CNT_RST  = 6'd50;
  localparam logic [TRAIL_W-1:0] BYTE_PULSES    = 6'd8;

  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_INIT_SEEN = 3'd1,
    ST_TIMEOUT   = 3'd2,
    ST_DONE_OK   = 3'd3,
    ST_DONE_FAIL = 3'd4,
    ST_REJECT    = 3'd5
  } fscl_status_t;

  typedef struct packed {
    logic         is_pulse;
    logic         data_level;
    logic         prog_level;
    fscl_status_t status;
  } fscl_item_t;

  typedef struct packed {
    logic               load;
    logic               load_shift;
    logic               rotate;
    logic [BYTE_W-1:0]  data;
    logic [TRAIL_W-1:0] count;
    logic               step;
  } fscl_ser_ctl_t;

  typedef struct packed {
    logic active;
    logic data;
    logic last;
  } fscl_ser_sts_t;

endpackage

FILE: design/fscl_serializer.sv
module fscl_serializer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fscl_pkg::fscl_ser_ctl_t ctl,
  output fscl_pkg::fscl_ser_sts_t sts
);
  import fscl_pkg::*;

  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic [TRAIL_W-1:0] cnt_r, cnt_nxt;
  logic               rot_r, rot_nxt;

  always_comb begin
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    rot_nxt   = rot_r;
    if (ctl.load) begin
      cnt_nxt = ctl.count;
      rot_nxt = ctl.rotate;
      if (ctl.load_shift) begin
        shift_nxt = ctl.data;
      end
    end else if (ctl.step && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - 1'b1;
      if (rot_r) begin
        shift_nxt = {shift_r[BYTE_W-2:0], shift_r[BYTE_W-1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      cnt_r   <= '0;
      rot_r   <= 1'b0;
    end else begin
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
      rot_r   <= rot_nxt;
    end
  end

  // msb first while rotating, otherwise hold the level last driven
  assign sts.active = (cnt_r != '0);
  assign sts.data   = rot_r ? shift_r[BYTE_W-1] : shift_r[0];
  assign sts.last   = (cnt_r == TRAIL_W'(1));

endmodule

FILE: design/fpga_serial_config_loader_unit.sv
// channel  direction  tdata / index                         tuser          tlast
// in_      slave      [7:0] byte_value, [8] pin_level       [2:0] command  -
// out_     master     [0] data_level, [1] prog_level,       is_pulse       last
//                     [4:2] status
// cfg_     slave      index 0 init_poll_limit, 1 trailing   -              -
//
// a status-only item is held in sgl_r on accept, then passed to the output register
// a byte in PH_LOAD gives eight pulses from the shifter, one per cycle unless held
// a finish gives trail_r pulses, one per cycle unless held, or one status result
// the next item is taken while the last result still waits in the output register
// out_tready low holds the output register and pauses the shift register
// rst_n is synchronous: phase idle, counts cleared, registers back to 100 and 50
module fpga_serial_config_loader_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // byte_value, pin_level
  input  logic [fscl_pkg::CMD_W-1:0]      in_tuser,   // command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // data_level, prog_level, status
  output logic                            out_tuser,  // is_pulse
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fscl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fscl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fscl_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_LOAD = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [LIMIT_W-1:0] poll_cnt_r, poll_cnt_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [TRAIL_W-1:0] trail_r;
  logic               busy_r, busy_nxt;
  fscl_item_t         sgl_r, sgl_nxt;
  logic               out_valid_r, out_valid_nxt;
  fscl_item_t         out_item_r, out_item_nxt;
  logic               out_last_r, out_last_nxt;

  fscl_ser_ctl_t      ser_ctl;
  fscl_ser_sts_t      ser_sts;

  logic [CMD_W-1:0]   cmd;
  logic [BYTE_W-1:0]  byte_val;
  logic               pin;
  logic               accept;
  logic               emit;

  assign cmd      = in_tuser;
  assign byte_val = in_tdata[BYTE_W-1:0];
  assign pin      = in_tdata[BYTE_W];
  assign in_tready = !busy_r;
  assign accept   = in_tvalid && in_tready;
  assign emit     = busy_r && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= POLL_LIMIT_RST;
      trail_r <= TRAIL_CNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POLL_LIMIT: limit_r <= cfg_data[LIMIT_W-1:0];
        REG_TRAIL_CNT:  trail_r <= cfg_data[TRAIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    poll_cnt_nxt = poll_cnt_r;
    busy_nxt     = busy_r;
    sgl_nxt      = sgl_r;
    ser_ctl      = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_item_nxt = out_item_r;
    out_last_nxt = out_last_r;

    if (accept) begin
      busy_nxt = 1'b1;
      sgl_nxt  = '{is_pulse: 1'b0, data_level: 1'b0,
                   prog_level: (phase_r != PH_WAIT), status: ST_REJECT};
      case (cmd)
        CMD_START: begin
          phase_nxt    = PH_WAIT;
          poll_cnt_nxt = '0;
          sgl_nxt.prog_level = 1'b0;
          sgl_nxt.status     = ST_BUSY;
        end
        CMD_POLL: begin
          if (phase_r == PH_WAIT) begin
            if (poll_cnt_r >= limit_r) begin
              phase_nxt          = PH_IDLE;
              sgl_nxt.prog_level = 1'b1;
              sgl_nxt.status     = ST_TIMEOUT;
            end else begin
              poll_cnt_nxt = poll_cnt_r + 1'b1;
              if (pin) begin
                phase_nxt          = PH_LOAD;
                sgl_nxt.prog_level = 1'b1;
                sgl_nxt.status     = ST_INIT_SEEN;
              end else begin
                sgl_nxt.prog_level = 1'b0;
                sgl_nxt.status     = ST_BUSY;
              end
            end
          end
        end
        CMD_BYTE: begin
          if (phase_r == PH_LOAD) begin
            ser_ctl.load       = 1'b1;
            ser_ctl.load_shift = 1'b1;
            ser_ctl.rotate     = 1'b1;
            ser_ctl.data       = byte_val;
            ser_ctl.count      = BYTE_PULSES;
          end
        end
        CMD_FINISH: begin
          if (phase_r == PH_LOAD) begin
            phase_nxt      = PH_DONE;
            sgl_nxt.status = ST_BUSY;
            ser_ctl.load   = 1'b1;
            ser_ctl.count  = trail_r;
          end
        end
        CMD_DONE: begin
          if (phase_r == PH_DONE) begin
            phase_nxt          = PH_IDLE;
            sgl_nxt.data_level = 1'b1;
            sgl_nxt.status     = pin ? ST_DONE_OK : ST_DONE_FAIL;
          end
        end
        default: ;
      endcase
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      if (ser_sts.active) begin
        ser_ctl.step = 1'b1;
        out_item_nxt = '{is_pulse: 1'b1, data_level: ser_sts.data,
                         prog_level: 1'b1, status: ST_BUSY};
        out_last_nxt = ser_sts.last;
        busy_nxt     = !ser_sts.last;
      end else begin
        out_item_nxt = sgl_r;
        out_last_nxt = 1'b1;
        busy_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      poll_cnt_r  <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      poll_cnt_r  <= poll_cnt_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sgl_r      <= sgl_nxt;
    out_item_r <= out_item_nxt;
    out_last_r <= out_last_nxt;
  end

  fscl_serializer u_ser (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ser_ctl),
    .sts   (ser_sts)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_item_r.is_pulse;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_item_r.status, out_item_r.prog_level,
                       out_item_r.data_level};

endmodule
